// ----- rtl/core/bgl_pkg.sv -----
// ----------------------------------------------------------------------------
// bgl_pkg
// Shared widths and types for the binary GCD / LCM block.
// ----------------------------------------------------------------------------
package bgl_pkg;

  // operand and result width
  localparam int WIDTH = 32;

  // shift count for the common power of two (0 .. WIDTH-1)
  localparam int KW = $clog2(WIDTH);

  // step counter for the divider and multiplier (WIDTH-1 down to 0)
  localparam int CW = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [KW-1:0]    shift_t;
  typedef logic [CW-1:0]    step_t;

endpackage

// ----- rtl/core/bgl_gcd.sv -----
// ----------------------------------------------------------------------------
// bgl_gcd
// Stein's binary GCD: one shift or one subtraction per cycle.
// ----------------------------------------------------------------------------
module bgl_gcd import bgl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t op_a,
  input  word_t op_b,
  output logic  done,
  output word_t result
);

  localparam logic [1:0] G_IDLE   = 2'd0;
  localparam logic [1:0] G_COMMON = 2'd1;
  localparam logic [1:0] G_REDUCE = 2'd2;

  logic [1:0] state;
  word_t      a;
  word_t      b;
  shift_t     k;

  // single shared subtractor: larger minus smaller
  logic  a_gt;
  word_t sub_hi;
  word_t sub_lo;
  word_t diff;

  assign a_gt   = a > b;
  assign sub_hi = a_gt ? a : b;
  assign sub_lo = a_gt ? b : a;
  assign diff   = sub_hi - sub_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) begin
            a <= op_a;
            b <= op_b;
            k <= '0;
            if (op_a == '0 || op_b == '0) begin
              // one side zero: the other side is the answer
              result <= op_a | op_b;
              done   <= 1'b1;
            end else begin
              state <= G_COMMON;
            end
          end
        end
        G_COMMON: begin
          // strip the common power of two
          if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else begin
            state <= G_REDUCE;
          end
        end
        G_REDUCE: begin
          priority if (!a[0]) begin
            a <= a >> 1;
          end else if (b == '0) begin
            result <= a << k;
            done   <= 1'b1;
            state  <= G_IDLE;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else begin
            // both odd: keep the smaller, replace the larger by the difference
            a <= sub_lo;
            b <= diff;
          end
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/bgl_div.sv -----
// ----------------------------------------------------------------------------
// bgl_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgl_div import bgl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t denom,
  output logic  done,
  output word_t quotient
);

  logic          busy;
  step_t         step;
  word_t         rem;
  word_t         den;
  logic [WIDTH:0] trial_in;
  logic [WIDTH:0] trial;
  logic          neg;

  assign trial_in = {rem, quotient[WIDTH-1]};
  assign trial    = trial_in - {1'b0, den};
  assign neg      = trial[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= CW'(WIDTH - 1);
        rem      <= '0;
        den      <= denom;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= neg ? trial_in[WIDTH-1:0] : trial[WIDTH-1:0];
        quotient <= {quotient[WIDTH-2:0], ~neg};
        step     <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/bgl_mul.sv -----
// ----------------------------------------------------------------------------
// bgl_mul
// Shift-and-add multiplier, one multiplier bit per cycle, full-width product.
// ----------------------------------------------------------------------------
module bgl_mul import bgl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t op_x,
  input  word_t op_y,
  output logic  done,
  output word_t prod_hi,
  output word_t prod_lo
);

  logic           busy;
  step_t          step;
  word_t          mcand;
  logic [WIDTH:0] sum;

  assign sum = prod_lo[0] ? ({1'b0, prod_hi} + {1'b0, mcand}) : {1'b0, prod_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        step    <= CW'(WIDTH - 1);
        mcand   <= op_y;
        prod_hi <= '0;
        prod_lo <= op_x;
      end else if (busy) begin
        prod_hi <= sum[WIDTH:1];
        prod_lo <= {sum[0], prod_lo[WIDTH-1:1]};
        step    <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/binary_gcd_lcm.sv -----
// ----------------------------------------------------------------------------
// binary_gcd_lcm
// GCD (Stein's binary method) and LCM of two unsigned operands.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   input   | in_valid, in_stall | operand_a, operand_b
//   output  | out_valid,out_stall| divisor, multiple, multiple_overflow
//
// One transaction at a time. A zero operand skips the divider and multiplier.
// Otherwise the GCD loop takes one shift or one subtraction per cycle,
// then the divider and then the multiplier run in turn.
// Reset (rst, synchronous) returns every sequencer to idle; no result pending.
// in_stall is high from acceptance until the result has been taken; a held
// result waits in the output registers for as long as out_stall is high.
// ----------------------------------------------------------------------------
module binary_gcd_lcm import bgl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  word_t operand_a,
  input  word_t operand_b,
  output logic  out_valid,
  input  logic  out_stall,
  output word_t divisor,
  output word_t multiple,
  output logic  multiple_overflow
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;

  // operands ordered for the LCM: (big / gcd) * small
  word_t big;
  word_t small_op;
  logic  any_zero;

  logic  gcd_start;
  logic  gcd_done;
  word_t gcd_result;
  logic  div_start;
  logic  div_done;
  word_t quotient;
  logic  mul_start;
  logic  mul_done;
  word_t prod_hi;
  word_t prod_lo;

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_DONE;

  assign gcd_start = in_valid && !in_stall;
  assign div_start = (state == S_GCD) && gcd_done && !any_zero;
  assign mul_start = (state == S_DIV) && div_done;

  bgl_gcd u_gcd (
    .clk    (clk),
    .rst    (rst),
    .start  (gcd_start),
    .op_a   (operand_a),
    .op_b   (operand_b),
    .done   (gcd_done),
    .result (gcd_result)
  );

  bgl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (big),
    .denom    (gcd_result),
    .done     (div_done),
    .quotient (quotient)
  );

  bgl_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .op_x    (quotient),
    .op_y    (small_op),
    .done    (mul_done),
    .prod_hi (prod_hi),
    .prod_lo (prod_lo)
  );

  // Sequencer: GCD, then divide, then multiply; result held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (gcd_start) begin
            big      <= (operand_a > operand_b) ? operand_a : operand_b;
            small_op <= (operand_a > operand_b) ? operand_b : operand_a;
            any_zero <= (operand_a == '0) || (operand_b == '0);
            state    <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            divisor <= gcd_result;
            if (any_zero) begin
              // zero operand: multiple is zero, never overflows
              multiple          <= '0;
              multiple_overflow <= 1'b0;
              state             <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            multiple          <= prod_lo;
            multiple_overflow <= |prod_hi;
            state             <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the units only finish while the sequencer waits on them
  a_gcd_done_in_gcd: assert property (@(posedge clk) disable iff (rst)
    gcd_done |-> state == S_GCD)
    else $error("gcd unit finished outside the GCD phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  // a zero divisor only comes from two zero operands, whose multiple is zero
  a_zero_divisor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divisor == '0) |-> (multiple == '0 && !multiple_overflow))
    else $error("non-zero multiple with zero divisor");

  // multiplier start only follows the divider immediately
  a_mul_after_div: assert property (@(posedge clk) disable iff (rst)
    mul_start |=> state == S_MUL)
    else $error("multiplier started without entering the multiply phase");
`endif

endmodule

// ----- verif/tb_binary_gcd_lcm.sv -----
// ----------------------------------------------------------------------------
// tb_binary_gcd_lcm
// Self-checking bench for the binary GCD / LCM block. Directed corner
// operands are followed by about 1400 random pairs drawn from several
// shapes: shared factors, powers of two, zeros and near-overflow products.
// Each accepted transaction is predicted in the scoreboard. Every result is
// compared field by field with the oldest prediction. Both channels idle
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_binary_gcd_lcm;
  import bgl_pkg::*;

  localparam int N_RANDOM    = 1400;
  localparam int QUIET_TAIL  = 150;           // last transactions run with no idling
  localparam int HOLD_AT     = 500;           // random transaction that starts the long hold
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 5 * WIDTH + 16; // worst GCD loop, divider and multiplier
  localparam int CYCLE_LIMIT = 1_500_000;

  localparam word_t ALL_ONES = '1;
  localparam word_t TOP_BIT  = word_t'(1) << (WIDTH - 1);

  // predicted result of one transaction
  typedef struct {
    word_t divisor;
    word_t multiple;
    logic  overflow;
  } gcd_lcm_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts GCD / LCM for each accepted operand pair and holds
  // the predictions in order until the matching result comes out.
  // --------------------------------------------------------------------------
  class gcd_lcm_scoreboard;
    gcd_lcm_t pending_results[$];
    int       errors;
    int       checked;
    int       noted;
    int       overflows;
    int       zero_operands;

    function new();
      errors        = 0;
      checked       = 0;
      noted         = 0;
      overflows     = 0;
      zero_operands = 0;
    endfunction

    // Stein's method: strip the common power of two, then reduce the odd
    // parts by subtracting the lesser from the greater
    function word_t stein_divisor(word_t a, word_t b);
      word_t x;
      word_t y;
      word_t t;
      int    common;
      if (a == '0) return b;
      if (b == '0) return a;
      common = 0;
      t = a | b;
      while (!t[0]) begin
        t = t >> 1;
        common++;
      end
      x = a;
      y = b;
      while (!x[0]) x = x >> 1;
      while (y != '0) begin
        while (!y[0]) y = y >> 1;
        if (x > y) begin
          t = x;
          x = y;
          y = t;
        end
        y = y - x;
      end
      return x << common;
    endfunction

    function gcd_lcm_t predict(word_t a, word_t b);
      gcd_lcm_t r;
      word_t    greater;
      word_t    lesser;
      word_t    quotient;
      r.divisor  = stein_divisor(a, b);
      r.multiple = '0;
      r.overflow = 1'b0;
      if (a != '0 && b != '0) begin
        greater    = (a > b) ? a : b;
        lesser     = (a > b) ? b : a;
        quotient   = greater / r.divisor;
        r.overflow = (quotient > ALL_ONES / lesser);
        r.multiple = quotient * lesser;   // kept to WIDTH bits
      end
      return r;
    endfunction

    function void note_operands(word_t a, word_t b);
      gcd_lcm_t r;
      r = predict(a, b);
      pending_results.push_back(r);
      noted++;
      if (r.overflow) overflows++;
      if (a == '0 || b == '0) zero_operands++;
    endfunction

    function void check_result(word_t d, word_t m, logic ovf);
      gcd_lcm_t w;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: divisor %h multiple %h overflow %b", d, m, ovf);
        errors++;
        return;
      end
      w = pending_results.pop_front();
      checked++;
      if (d !== w.divisor) begin
        $error("divisor mismatch: expected %h, actual %h", w.divisor, d);
        errors++;
      end
      if (m !== w.multiple) begin
        $error("multiple mismatch: expected %h, actual %h", w.multiple, m);
        errors++;
      end
      if (ovf !== w.overflow) begin
        $error("multiple_overflow mismatch: expected %b, actual %b", w.overflow, ovf);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and stimulus signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  word_t operand_a = '0;
  word_t operand_b = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  word_t divisor;
  word_t multiple;
  logic  multiple_overflow;

  gcd_lcm_scoreboard sb = new();

  bit idle_on        = 1'b1;  // random gaps on both sides
  bit long_hold_req  = 1'b0;  // asks the receiver for one long hold-off

  always #1 clk = ~clk;

  binary_gcd_lcm dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operand_a         (operand_a),
    .operand_b         (operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .divisor           (divisor),
    .multiple          (multiple),
    .multiple_overflow (multiple_overflow)
  );

  // --------------------------------------------------------------------------
  // Sender: optional gap, then offer the pair and hold it until accepted.
  // in_valid is only lowered when a gap follows, so it never toggles twice
  // in one step between back-to-back transactions.
  // --------------------------------------------------------------------------
  task automatic send_operands(input word_t a, input word_t b);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    // values read here are those from before the edge
    do @(posedge clk); while (in_stall);
    sb.note_operands(a, b);
  endtask

  // random operand pair, mixing shapes that reach the different loop paths
  task automatic random_pair(output word_t a, output word_t b);
    word_t g;
    int    shape;
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1, 2: begin
        a = $urandom;
        b = $urandom;
      end
      3: begin                          // shared odd-ish factor
        g = $urandom_range(1, 65536);
        a = g * word_t'($urandom_range(1, 65535));
        b = g * word_t'($urandom_range(1, 65535));
      end
      4: begin                          // shared power of two
        a = word_t'($urandom) << $urandom_range(0, WIDTH - 1);
        b = word_t'($urandom) << $urandom_range(0, WIDTH - 1);
        if (a == '0) a = TOP_BIT;
      end
      5: begin
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
      6: begin                          // one zero operand
        if ($urandom_range(0, 1)) begin
          a = '0;
          b = $urandom;
        end else begin
          a = $urandom;
          b = '0;
        end
      end
      7: begin
        a = $urandom;
        b = a;
      end
      8: begin                          // products around the WIDTH-bit boundary
        a = $urandom_range(1, 65535) + 32768;
        b = $urandom_range(1, 65535) + 32768;
      end
      default: begin                    // single bits and their complements
        a = word_t'(1) << $urandom_range(0, WIDTH - 1);
        b = $urandom_range(0, 1) ? ~(word_t'(1) << $urandom_range(0, WIDTH - 1))
                                 : word_t'($urandom);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, free-running stretches, and one long
  // hold-off on request so the block stays busy and holds in_stall high
  // --------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // output monitor: a transaction completes when out_valid is high and
  // out_stall low at the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(divisor, multiple, multiple_overflow);
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("binary_gcd_lcm test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    word_t a;
    word_t b;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corners: zeros, ones, all-ones, top bit, exact fit and
    // just-over-fit products, large primes
    send_operands('0, '0);
    send_operands('0, 32'h1234_5678);
    send_operands(32'hDEAD_BEEF, '0);
    send_operands('0, ALL_ONES);
    send_operands(1, 1);
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES, 1);
    send_operands(1, ALL_ONES);
    send_operands(ALL_ONES, ALL_ONES - 1);
    send_operands(TOP_BIT, TOP_BIT);
    send_operands(TOP_BIT, TOP_BIT >> 1);
    send_operands(TOP_BIT, ALL_ONES);
    send_operands(ALL_ONES - 1, TOP_BIT);
    send_operands(12, 18);
    send_operands(18, 12);
    send_operands(65535, 65537);      // lcm is exactly all-ones
    send_operands(65536, 65537);      // lcm just over WIDTH bits
    send_operands(3, ALL_ONES);
    send_operands(32'hFFFF_FFFB, 32'hFFFF_FFEF);
    send_operands(2, TOP_BIT | 1);
    send_operands(32'h5555_5555, 32'hAAAA_AAAA);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) long_hold_req = 1'b1;
      if (i == N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
      random_pair(a, b);
      send_operands(a, b);
    end
    in_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions (%0d results checked): %0d lcm overflows, %0d with a zero",
             sb.noted, sb.checked, sb.overflows, sb.zero_operands);
    $display("operand, random idling on both channels and one long output hold-off.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("binary_gcd_lcm test passed");
    end else begin
      $display("binary_gcd_lcm test failed");
    end
    $finish;
  end

endmodule
